### hw/rtl/fcgp_pkg.sv
package fcgp_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk          = 2'd0,
    StatusOutOfOrder  = 2'd1,
    StatusGapTooLarge = 2'd2
  } status_e;

  // Configuration register indexes (byte address is 4 times the index).
  typedef enum logic [1:0] {
    RegPadGaps       = 2'd0,
    RegMaxPadFrames  = 2'd1,
    RegBurstSynth    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CtlIdle,
    CtlPad
  } ctl_state_e;

  localparam int unsigned CfgAddrWidth       = 4;
  localparam int unsigned PadCntWidth        = 6;
  localparam logic [PadCntWidth-1:0] MaxPad  = 6'd63;
  localparam logic [PadCntWidth-1:0] MaxPadFramesReset = 6'd16;

  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic emit_pad;   // load the next padding plan
    logic emit_real;  // load the real frame plan after padding
    logic pop;        // output transaction taken this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;  // output register holds a result
    logic need_pad;   // the offered frame opens a padding burst
    logic pad_more;   // padding plans still to load
  } dp_status_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] out_index;
    logic [31:0] source_index;
    logic        is_padding;
    logic        plan_counter_valid;
    logic [31:0] plan_counter;
    logic        gap_seen;
    logic [30:0] missing_count;
    logic        gap_padded;
    logic [31:0] prior_counter;
    logic        signal_locked;
    logic        last;
  } result_t;

endpackage

### hw/rtl/fcgp_ctrl.sv
module fcgp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  input  fcgp_pkg::dp_status_t sts_i,
  output fcgp_pkg::dp_cmd_t    cmd_o
);

  fcgp_pkg::ctl_state_e state_q, state_d;
  logic                 adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcgp_pkg::CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    // The output register can take a new result when empty or being drained.
    adv           = !sts_i.out_valid || out_ready_i;
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.pop     = sts_i.out_valid && out_ready_i;
    unique case (state_q)
      fcgp_pkg::CtlIdle: begin
        in_ready_o   = adv;
        cmd_o.accept = adv && in_valid_i;
        if (cmd_o.accept && sts_i.need_pad) begin
          state_d = fcgp_pkg::CtlPad;
        end
      end
      fcgp_pkg::CtlPad: begin
        cmd_o.emit_pad  = adv && sts_i.pad_more;
        cmd_o.emit_real = adv && !sts_i.pad_more;
        if (cmd_o.emit_real) begin
          state_d = fcgp_pkg::CtlIdle;
        end
      end
      default: begin
        state_d = fcgp_pkg::CtlIdle;
      end
    endcase
  end

endmodule

### hw/rtl/fcgp_dp.sv
module fcgp_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fcgp_pkg::dp_cmd_t     cmd_i,
  output fcgp_pkg::dp_status_t  sts_o,
  input  logic                  pad_gaps_i,
  input  logic [5:0]            max_pad_frames_i,
  input  logic                  burst_synthesised_i,
  input  logic [31:0]           stored_index_i,
  input  logic                  counter_present_i,
  input  logic [31:0]           counter_value_i,
  output fcgp_pkg::result_t     res_o,
  output logic                  out_valid_o
);

  // Frame history and output counter.
  logic        have_prior_q, have_prior_d;
  logic [31:0] prior_idx_q, prior_idx_d;
  logic        prior_cv_q, prior_cv_d;
  logic [31:0] prior_cval_q, prior_cval_d;
  logic [31:0] count_q, count_d;
  logic        broken_q, broken_d;

  // Output register and the frame held during a padding burst.
  logic                               out_valid_q, out_valid_d;
  fcgp_pkg::result_t                  res_q, res_d;
  logic [fcgp_pkg::PadCntWidth-1:0]   pad_left_q, pad_left_d;
  logic [31:0]                        it_sidx_q, it_sidx_d;
  logic                               it_cpres_q, it_cpres_d;
  logic [31:0]                        it_pcval_q, it_pcval_d;
  logic [fcgp_pkg::PadCntWidth-1:0]   it_miss_q, it_miss_d;
  logic [31:0]                        it_prior_q, it_prior_d;

  // Decision on the offered frame.
  logic [fcgp_pkg::PadCntWidth-1:0] limit;
  logic [31:0] step;
  logic [31:0] pcval;
  logic [30:0] miss;
  logic        ooo, step_ok, gap, forward, over, gap_ok, need_pad, set_brk;
  fcgp_pkg::result_t res_final, res_real;

  function automatic fcgp_pkg::result_t pad_plan(logic [31:0] oidx, logic [31:0] sidx,
                                                 logic locked);
    fcgp_pkg::result_t r;
    r               = '0;
    r.status        = fcgp_pkg::StatusOk;
    r.out_index     = oidx;
    r.source_index  = sidx;
    r.is_padding    = 1'b1;
    r.signal_locked = locked;
    r.last          = 1'b0;
    return r;
  endfunction

  always_comb begin
    limit     = (max_pad_frames_i < fcgp_pkg::MaxPad) ? max_pad_frames_i : fcgp_pkg::MaxPad;
    pcval     = counter_present_i ? counter_value_i : 32'd0;
    step      = counter_value_i - prior_cval_q;
    ooo       = have_prior_q && (stored_index_i <= prior_idx_q);
    step_ok   = have_prior_q && prior_cv_q && counter_present_i;
    gap       = step_ok && (step != 32'd1);
    // A forward step lies in 2 .. 2^31-1.
    forward   = !step[31] && (step > 32'd1);
    miss      = forward ? (step[30:0] - 31'd1) : 31'd0;
    gap_ok    = gap && !ooo;
    over      = pad_gaps_i && gap_ok && forward &&
                ((miss[30:fcgp_pkg::PadCntWidth] != '0) ||
                 (miss[fcgp_pkg::PadCntWidth-1:0] > limit));
    need_pad  = gap_ok && pad_gaps_i && forward && !over;
    set_brk   = gap_ok && !over && !(pad_gaps_i && forward);

    res_final                    = '0;
    res_final.status             = ooo  ? fcgp_pkg::StatusOutOfOrder :
                                   over ? fcgp_pkg::StatusGapTooLarge : fcgp_pkg::StatusOk;
    res_final.out_index          = count_q;
    res_final.source_index       = stored_index_i;
    res_final.is_padding         = 1'b0;
    res_final.plan_counter_valid = counter_present_i;
    res_final.plan_counter       = pcval;
    res_final.gap_seen           = gap_ok;
    res_final.missing_count      = gap_ok ? miss : 31'd0;
    res_final.gap_padded         = 1'b0;
    res_final.prior_counter      = gap_ok ? prior_cval_q : 32'd0;
    res_final.signal_locked      = burst_synthesised_i && !(broken_q || set_brk);
    res_final.last               = 1'b1;

    res_real                     = '0;
    res_real.status              = fcgp_pkg::StatusOk;
    res_real.out_index           = count_q;
    res_real.source_index        = it_sidx_q;
    res_real.is_padding          = 1'b0;
    res_real.plan_counter_valid  = it_cpres_q;
    res_real.plan_counter        = it_pcval_q;
    res_real.gap_seen            = 1'b1;
    res_real.missing_count       = {{(31-fcgp_pkg::PadCntWidth){1'b0}}, it_miss_q};
    res_real.gap_padded          = 1'b1;
    res_real.prior_counter       = it_prior_q;
    res_real.signal_locked       = burst_synthesised_i && !broken_q;
    res_real.last                = 1'b1;
  end

  always_comb begin
    have_prior_d = have_prior_q;
    prior_idx_d  = prior_idx_q;
    prior_cv_d   = prior_cv_q;
    prior_cval_d = prior_cval_q;
    count_d      = count_q;
    broken_d     = broken_q;
    out_valid_d  = out_valid_q && !cmd_i.pop;
    res_d        = res_q;
    pad_left_d   = pad_left_q;
    it_sidx_d    = it_sidx_q;
    it_cpres_d   = it_cpres_q;
    it_pcval_d   = it_pcval_q;
    it_miss_d    = it_miss_q;
    it_prior_d   = it_prior_q;

    if (cmd_i.accept) begin
      out_valid_d = 1'b1;
      if (need_pad) begin
        res_d      = pad_plan(count_q, stored_index_i, burst_synthesised_i && !broken_q);
        count_d    = count_q + 32'd1;
        pad_left_d = miss[fcgp_pkg::PadCntWidth-1:0] - 1'b1;
        it_sidx_d  = stored_index_i;
        it_cpres_d = counter_present_i;
        it_pcval_d = pcval;
        it_miss_d  = miss[fcgp_pkg::PadCntWidth-1:0];
        it_prior_d = prior_cval_q;
      end else begin
        res_d = res_final;
        if (!ooo && !over) begin
          count_d      = count_q + 32'd1;
          have_prior_d = 1'b1;
          prior_idx_d  = stored_index_i;
          prior_cv_d   = counter_present_i;
          prior_cval_d = pcval;
          broken_d     = broken_q || set_brk;
        end
      end
    end else if (cmd_i.emit_pad) begin
      out_valid_d = 1'b1;
      res_d       = pad_plan(count_q, it_sidx_q, burst_synthesised_i && !broken_q);
      count_d     = count_q + 32'd1;
      pad_left_d  = pad_left_q - 1'b1;
    end else if (cmd_i.emit_real) begin
      out_valid_d  = 1'b1;
      res_d        = res_real;
      count_d      = count_q + 32'd1;
      have_prior_d = 1'b1;
      prior_idx_d  = it_sidx_q;
      prior_cv_d   = it_cpres_q;
      prior_cval_d = it_pcval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prior_q <= 1'b0;
      prior_idx_q  <= '0;
      prior_cv_q   <= 1'b0;
      prior_cval_q <= '0;
      count_q      <= '0;
      broken_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      pad_left_q   <= '0;
    end else begin
      have_prior_q <= have_prior_d;
      prior_idx_q  <= prior_idx_d;
      prior_cv_q   <= prior_cv_d;
      prior_cval_q <= prior_cval_d;
      count_q      <= count_d;
      broken_q     <= broken_d;
      out_valid_q  <= out_valid_d;
      pad_left_q   <= pad_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    it_sidx_q  <= it_sidx_d;
    it_cpres_q <= it_cpres_d;
    it_pcval_q <= it_pcval_d;
    it_miss_q  <= it_miss_d;
    it_prior_q <= it_prior_d;
  end

  assign sts_o.out_valid = out_valid_q;
  assign sts_o.need_pad  = need_pad;
  assign sts_o.pad_more  = (pad_left_q != '0);
  assign res_o           = res_q;
  assign out_valid_o     = out_valid_q;

endmodule

### hw/rtl/frame_counter_gap_padder.sv
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    stored_index_i, counter_present_i,
//                                                 counter_value_i
// output    out        out_valid_o / out_ready_i  status_o .. last_o, one plan each
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Frames without padding stream at one per cycle while the output is not stalled.
// A frame padded with N plans gives N+1 plans, padding first; the single output
// register loads one plan per cycle while it is not stalled.
// Reset clears the frame history and counters at once; there is no clearing pass.
// A stalled output holds its plan, and a new frame is taken only when the output
// register is empty or being drained in the same cycle.
module frame_counter_gap_padder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] stored_index_i,
  input  logic        counter_present_i,
  input  logic [31:0] counter_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_index_o,
  output logic [31:0] source_index_o,
  output logic        is_padding_o,
  output logic        plan_counter_valid_o,
  output logic [31:0] plan_counter_o,
  output logic        gap_seen_o,
  output logic [30:0] missing_count_o,
  output logic        gap_padded_o,
  output logic [31:0] prior_counter_o,
  output logic        signal_locked_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [fcgp_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 pad_gaps_q;
  logic [5:0]           max_pad_frames_q;
  logic                 burst_q;
  logic                 cfg_wr;
  fcgp_pkg::reg_idx_e   reg_idx;
  fcgp_pkg::dp_cmd_t    cmd;
  fcgp_pkg::dp_status_t sts;
  fcgp_pkg::result_t    res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = fcgp_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_gaps_q       <= 1'b0;
      max_pad_frames_q <= fcgp_pkg::MaxPadFramesReset;
      burst_q          <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        fcgp_pkg::RegPadGaps:      pad_gaps_q       <= pwdata[0];
        fcgp_pkg::RegMaxPadFrames: max_pad_frames_q <= pwdata[5:0];
        fcgp_pkg::RegBurstSynth:   burst_q          <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fcgp_pkg::RegPadGaps:      prdata = {31'd0, pad_gaps_q};
      fcgp_pkg::RegMaxPadFrames: prdata = {26'd0, max_pad_frames_q};
      fcgp_pkg::RegBurstSynth:   prdata = {31'd0, burst_q};
      default:                   prdata = 32'd0;
    endcase
  end

  fcgp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fcgp_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .pad_gaps_i          (pad_gaps_q),
    .max_pad_frames_i    (max_pad_frames_q),
    .burst_synthesised_i (burst_q),
    .stored_index_i      (stored_index_i),
    .counter_present_i   (counter_present_i),
    .counter_value_i     (counter_value_i),
    .res_o               (res),
    .out_valid_o         (out_valid_o)
  );

  assign status_o             = res.status;
  assign out_index_o          = res.out_index;
  assign source_index_o       = res.source_index;
  assign is_padding_o         = res.is_padding;
  assign plan_counter_valid_o = res.plan_counter_valid;
  assign plan_counter_o       = res.plan_counter;
  assign gap_seen_o           = res.gap_seen;
  assign missing_count_o      = res.missing_count;
  assign gap_padded_o         = res.gap_padded;
  assign prior_counter_o      = res.prior_counter;
  assign signal_locked_o      = res.signal_locked;
  assign last_o               = res.last;

`ifndef SYNTHESIS
  // A new frame is never taken while a result is stuck in the output register.
  a_ready_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input ready while output register is stalled");

  // Padding plans always precede the real frame plan.
  a_pad_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_padding_o) |-> !last_o)
    else $error("padding plan marked last");

  // While a padding burst drains, no new frame is accepted.
  a_no_accept_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |-> !in_ready_o)
    else $error("frame accepted inside a padding burst");

  // A rejected frame yields a single, final result.
  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != fcgp_pkg::StatusOk)) |-> (last_o && !is_padding_o))
    else $error("rejected frame result not final");

  // The output index advances by one after every delivered ok plan.
  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && (status_o == fcgp_pkg::StatusOk)) |=>
      (!out_valid_o || (out_index_o == $past(out_index_o) + 32'd1)))
    else $error("output index did not advance by one");
`endif

endmodule
